// ===== design/stcon_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, codes and the scan code decode table for the scan code console.
// No dependencies; used by the front end, back end, top level and bench.
package stcon_pkg;

  localparam int COL_W  = 7;
  localparam int ROW_W  = 5;
  localparam int POS_W  = 11;
  localparam int LEN_W  = 8;
  localparam int SLOT_W = 7;
  localparam int CHAR_W = 8;

  // Set-1 codes
  localparam logic [7:0] CODE_PREFIX    = 8'hE0;
  localparam logic [7:0] CODE_LEFT      = 8'h4B;
  localparam logic [7:0] CODE_RIGHT     = 8'h4D;
  localparam logic [7:0] CODE_UP        = 8'h48;
  localparam logic [7:0] CODE_DOWN      = 8'h50;
  localparam logic [7:0] CODE_ENTER_UP  = 8'h9C;
  localparam logic [7:0] CODE_BACKSPACE = 8'h0E;
  localparam logic [7:0] CODE_CAPS      = 8'h3A;

  localparam logic [7:0] ERASE_ATTR  = 8'h07;
  localparam logic [7:0] ATTR_RESET  = 8'd14;
  localparam logic [7:0] CHAR_NONE   = 8'h00;
  localparam logic [7:0] CHAR_SPACE  = 8'h20;
  localparam logic [7:0] CHAR_LOW_A  = 8'h61;
  localparam logic [7:0] CHAR_LOW_Z  = 8'h7A;
  localparam logic [7:0] CASE_OFFSET = 8'h20;

  localparam logic [ROW_W-1:0] ROW_RESET = 5'd2;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_TYPE,
    OP_LEFT,
    OP_RIGHT,
    OP_UP,
    OP_DOWN,
    OP_ENTER,
    OP_BACKSPACE,
    OP_CAPS
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [CHAR_W-1:0] ch;
  } cmd_t;

  typedef struct packed {
    logic              cell_write;
    logic [POS_W-1:0]  cell_position;
    logic [CHAR_W-1:0] cell_char;
    logic [7:0]        cell_attribute;
    logic              scroll_up;
    logic [POS_W-1:0]  cursor_position;
    logic              line_write;
    logic [SLOT_W-1:0] line_slot;
    logic [CHAR_W-1:0] line_char;
    logic [LEN_W-1:0]  line_length;
    logic              line_done;
  } result_t;

  // Lower-case character typed by a release code, CHAR_NONE otherwise
  function automatic logic [CHAR_W-1:0] decode_release(input logic [7:0] code);
    logic [CHAR_W-1:0] c;
    case (code)
      8'h82: c = "1";
      8'h83: c = "2";
      8'h84: c = "3";
      8'h85: c = "4";
      8'h86: c = "5";
      8'h87: c = "6";
      8'h88: c = "7";
      8'h89: c = "8";
      8'h8A: c = "9";
      8'h8B: c = "0";
      8'h90: c = "q";
      8'h91: c = "w";
      8'h92: c = "e";
      8'h93: c = "r";
      8'h94: c = "t";
      8'h95: c = "y";
      8'h96: c = "u";
      8'h97: c = "i";
      8'h98: c = "o";
      8'h99: c = "p";
      8'h9E: c = "a";
      8'h9F: c = "s";
      8'hA0: c = "d";
      8'hA1: c = "f";
      8'hA2: c = "g";
      8'hA3: c = "h";
      8'hA4: c = "j";
      8'hA5: c = "k";
      8'hA6: c = "l";
      8'hAC: c = "z";
      8'hAD: c = "x";
      8'hAE: c = "c";
      8'hAF: c = "v";
      8'hB0: c = "b";
      8'hB1: c = "n";
      8'hB2: c = "m";
      8'hB9: c = CHAR_SPACE;
      default: c = CHAR_NONE;
    endcase
    return c;
  endfunction

endpackage

// ===== design/stcon_fifo.sv =====
`timescale 1ns / 1ps
// Two-entry queue of WIDTH-bit beats with push/full and pop/empty sides.
// No package dependencies.
module stcon_fifo #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty
);

  logic [WIDTH-1:0] slots [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == 2'd2);
  assign empty   = (count == 2'd0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

endmodule

// ===== design/stcon_front.sv =====
`timescale 1ns / 1ps
// Front end: tracks the 0xE0 prefix and classifies each scan code into a command.
// Depends on stcon_pkg.
module stcon_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  logic [7:0]          key_code,
  output stcon_pkg::cmd_t     cmd
);

  logic                          extended_pending;
  logic [stcon_pkg::CHAR_W-1:0]  ch;

  assign ch = stcon_pkg::decode_release(key_code);

  always_comb begin
    cmd.ch = ch;
    if (key_code == stcon_pkg::CODE_PREFIX) begin
      cmd.op = stcon_pkg::OP_NONE;
    end else if (extended_pending && key_code == stcon_pkg::CODE_LEFT) begin
      cmd.op = stcon_pkg::OP_LEFT;
    end else if (extended_pending && key_code == stcon_pkg::CODE_RIGHT) begin
      cmd.op = stcon_pkg::OP_RIGHT;
    end else if (extended_pending && key_code == stcon_pkg::CODE_UP) begin
      cmd.op = stcon_pkg::OP_UP;
    end else if (extended_pending && key_code == stcon_pkg::CODE_DOWN) begin
      cmd.op = stcon_pkg::OP_DOWN;
    end else if (ch != stcon_pkg::CHAR_NONE) begin
      cmd.op = stcon_pkg::OP_TYPE;
    end else if (key_code == stcon_pkg::CODE_ENTER_UP) begin
      cmd.op = stcon_pkg::OP_ENTER;
    end else if (key_code == stcon_pkg::CODE_BACKSPACE) begin
      cmd.op = stcon_pkg::OP_BACKSPACE;
    end else if (key_code == stcon_pkg::CODE_CAPS) begin
      cmd.op = stcon_pkg::OP_CAPS;
    end else begin
      cmd.op = stcon_pkg::OP_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      extended_pending <= 1'b0;
    end else if (accept) begin
      extended_pending <= (key_code == stcon_pkg::CODE_PREFIX);
    end
  end

endmodule

// ===== design/stcon_back.sv =====
`timescale 1ns / 1ps
// Back end: cursor, caps lock and line length state; turns one command into one result.
// Depends on stcon_pkg.
module stcon_back #(
  parameter int LINE_CAPACITY  = 128,
  parameter int SCREEN_COLUMNS = 80,
  parameter int SCREEN_ROWS    = 25
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [7:0]           text_attribute,
  input  stcon_pkg::cmd_t      cmd,
  input  logic                 cmd_empty,
  output logic                 cmd_pop,
  output stcon_pkg::result_t   res,
  output logic                 res_push,
  input  logic                 res_full
);

  localparam int CW = stcon_pkg::COL_W;
  localparam int RW = stcon_pkg::ROW_W;
  localparam int LW = stcon_pkg::LEN_W;
  localparam logic [CW:0]   COLS     = (CW + 1)'(SCREEN_COLUMNS);
  localparam logic [CW-1:0] LAST_COL = CW'(SCREEN_COLUMNS - 1);
  localparam logic [RW:0]   ROWS     = (RW + 1)'(SCREEN_ROWS);
  localparam logic [RW-1:0] LAST_ROW = RW'(SCREEN_ROWS - 1);
  localparam logic [LW-1:0] CAP      = LW'(LINE_CAPACITY);

  logic [CW-1:0] col, col_next;
  logic [RW-1:0] row, row_next;
  logic          caps, caps_next;
  logic [LW-1:0] line_count, line_count_next;
  logic [CW:0]   col_inc;
  logic [RW:0]   row_inc;
  logic [7:0]    typed;
  logic          step;

  function automatic logic [stcon_pkg::POS_W-1:0] cell_of(input logic [RW-1:0] r,
                                                          input logic [CW-1:0] c);
    logic [12:0] p;
    p = 13'(r) * 13'(SCREEN_COLUMNS) + 13'(c);
    return p[stcon_pkg::POS_W-1:0];
  endfunction

  assign step     = !cmd_empty && !res_full;
  assign cmd_pop  = step;
  assign res_push = step;
  assign col_inc  = {1'b0, col} + 1'b1;
  assign row_inc  = {1'b0, row} + 1'b1;
  assign typed    = (caps && cmd.ch >= stcon_pkg::CHAR_LOW_A && cmd.ch <= stcon_pkg::CHAR_LOW_Z)
                  ? cmd.ch - stcon_pkg::CASE_OFFSET : cmd.ch;

  always_comb begin
    col_next        = col;
    row_next        = row;
    caps_next       = caps;
    line_count_next = line_count;
    res             = '0;
    case (cmd.op)
      stcon_pkg::OP_LEFT: begin
        if (col != '0) col_next = col - 1'b1;
      end
      stcon_pkg::OP_RIGHT: begin
        if (col_inc < COLS) col_next = col_inc[CW-1:0];
      end
      stcon_pkg::OP_UP: begin
        if (row != '0) row_next = row - 1'b1;
      end
      stcon_pkg::OP_DOWN: begin
        if (row_inc < ROWS) row_next = row_inc[RW-1:0];
      end
      stcon_pkg::OP_TYPE: begin
        res.cell_write     = 1'b1;
        res.cell_position  = cell_of(row, col);
        res.cell_char      = typed;
        res.cell_attribute = text_attribute;
        if (col_inc >= COLS) begin
          col_next = '0;
          if (row_inc >= ROWS) begin
            row_next      = LAST_ROW;
            res.scroll_up = 1'b1;
          end else begin
            row_next = row_inc[RW-1:0];
          end
        end else begin
          col_next = col_inc[CW-1:0];
        end
        if (line_count < CAP) begin
          res.line_write  = 1'b1;
          res.line_slot   = line_count[stcon_pkg::SLOT_W-1:0];
          res.line_char   = typed;
          line_count_next = line_count + 1'b1;
        end
      end
      stcon_pkg::OP_ENTER: begin
        col_next = '0;
        if (row_inc < ROWS) row_next = row_inc[RW-1:0];
        line_count_next = '0;
        res.line_done   = 1'b1;
      end
      stcon_pkg::OP_BACKSPACE: begin
        if (col != '0) begin
          col_next = col - 1'b1;
        end else if (row != '0) begin
          row_next = row - 1'b1;
          col_next = LAST_COL;
        end
        res.cell_write     = 1'b1;
        res.cell_position  = cell_of(row_next, col_next);
        res.cell_char      = stcon_pkg::CHAR_SPACE;
        res.cell_attribute = stcon_pkg::ERASE_ATTR;
        if (line_count != '0) line_count_next = line_count - 1'b1;
      end
      stcon_pkg::OP_CAPS: begin
        caps_next = !caps;
      end
      default: begin
      end
    endcase
    res.cursor_position = cell_of(row_next, col_next);
    res.line_length     = line_count_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col        <= '0;
      row        <= stcon_pkg::ROW_RESET;
      caps       <= 1'b0;
      line_count <= '0;
    end else if (step) begin
      col        <= col_next;
      row        <= row_next;
      caps       <= caps_next;
      line_count <= line_count_next;
    end
  end

`ifndef NO_ASSERTIONS
  a_col_range: assert property (@(posedge clk) disable iff (rst)
    {1'b0, col} < COLS) else $error("cursor column out of range");
  a_row_range: assert property (@(posedge clk) disable iff (rst)
    $past(step) |-> {1'b0, row} < ROWS) else $error("cursor row out of range");
  a_line_cap: assert property (@(posedge clk) disable iff (rst)
    line_count <= CAP) else $error("line length above capacity");
  a_scroll_write: assert property (@(posedge clk) disable iff (rst)
    res.scroll_up |-> res.cell_write && res.line_done == 1'b0)
    else $error("scroll without a typed cell");
  a_same_char: assert property (@(posedge clk) disable iff (rst)
    (res.cell_write && res.line_write) |-> res.cell_char == res.line_char)
    else $error("screen and line store disagree on character");
`endif

endmodule

// ===== design/scancode_text_console_unit.sv =====
`timescale 1ns / 1ps
// Top level of the scan code text console: attribute register, front, queues, back.
// Depends on stcon_pkg, stcon_front, stcon_fifo, stcon_back.
//
//  channel   handshake            payload
//  -------   ------------------   ---------------------------------------------
//  input     push / full          key_code
//  result    pop / empty          cell_*, scroll_up, cursor_position, line_*
//  config    attr_write           attr_data (text_attribute, no read-back)
//
// One beat per cycle in both directions while the receiver keeps pop high; every scan code gives one result.
// A pushed byte is classified and written to the command queue; the back end pops it
// when the result queue has room, and its result shows on the result ports once queued.
// Stalls: a two-entry queue sits between front and back and another holds results,
// so a blocked pop backs up to full after four beats without losing any.
// rst (synchronous) empties both queues, clears the prefix flag, caps lock and line
// length, puts the cursor at column 0, row 2 and the attribute back to 14.
module scancode_text_console_unit #(
  parameter int LINE_CAPACITY  = 128,
  parameter int SCREEN_COLUMNS = 80,
  parameter int SCREEN_ROWS    = 25
) (
  input  logic        clk,
  input  logic        rst,
  // input beats
  input  logic        push,
  output logic        full,
  input  logic [7:0]  key_code,
  // configuration
  input  logic        attr_write,
  input  logic [7:0]  attr_data,
  // result beats
  output logic        empty,
  input  logic        pop,
  output logic        cell_write,
  output logic [10:0] cell_position,
  output logic [7:0]  cell_char,
  output logic [7:0]  cell_attribute,
  output logic        scroll_up,
  output logic [10:0] cursor_position,
  output logic        line_write,
  output logic [6:0]  line_slot,
  output logic [7:0]  line_char,
  output logic [7:0]  line_length,
  output logic        line_done
);

  localparam int CMD_W = $bits(stcon_pkg::cmd_t);
  localparam int RES_W = $bits(stcon_pkg::result_t);

  logic               accept;
  logic [7:0]         text_attribute;
  stcon_pkg::cmd_t    front_cmd;
  stcon_pkg::cmd_t    back_cmd;
  logic               cmd_empty;
  logic               cmd_pop;
  stcon_pkg::result_t back_res;
  logic               res_push;
  logic               res_full;
  stcon_pkg::result_t head;

  assign accept = push && !full;

  // Attribute register; the user must write it only while idle (the block does not enforce this)
  always_ff @(posedge clk) begin
    if (rst) begin
      text_attribute <= stcon_pkg::ATTR_RESET;
    end else if (attr_write) begin
      text_attribute <= attr_data;
    end
  end

  // Prefix tracking and command classification
  stcon_front u_front (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .key_code (key_code),
    .cmd      (front_cmd)
  );

  // Command queue between front and back; its full flag is the input full
  stcon_fifo #(.WIDTH(CMD_W)) u_cmd_q (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .din   (front_cmd),
    .full  (full),
    .pop   (cmd_pop),
    .dout  (back_cmd),
    .empty (cmd_empty)
  );

  // Cursor, caps and line state; one command per cycle when the result queue has room
  stcon_back #(
    .LINE_CAPACITY  (LINE_CAPACITY),
    .SCREEN_COLUMNS (SCREEN_COLUMNS),
    .SCREEN_ROWS    (SCREEN_ROWS)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .text_attribute (text_attribute),
    .cmd            (back_cmd),
    .cmd_empty      (cmd_empty),
    .cmd_pop        (cmd_pop),
    .res            (back_res),
    .res_push       (res_push),
    .res_full       (res_full)
  );

  // Result queue; its head is what the result ports show
  stcon_fifo #(.WIDTH(RES_W)) u_res_q (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .din   (back_res),
    .full  (res_full),
    .pop   (pop),
    .dout  (head),
    .empty (empty)
  );

  assign cell_write      = head.cell_write;
  assign cell_position   = head.cell_position;
  assign cell_char       = head.cell_char;
  assign cell_attribute  = head.cell_attribute;
  assign scroll_up       = head.scroll_up;
  assign cursor_position = head.cursor_position;
  assign line_write      = head.line_write;
  assign line_slot       = head.line_slot;
  assign line_char       = head.line_char;
  assign line_length     = head.line_length;
  assign line_done       = head.line_done;

endmodule

// ===== bench/tb_scancode_text_console_unit.sv =====
`timescale 1ns / 1ps
// Self-checking bench for scancode_text_console_unit: scan code bytes in, console beats out.
// Depends on stcon_pkg and the design files; holds its own console model as a scoreboard class.
module tb_scancode_text_console_unit;

  localparam int COLS        = 80;
  localparam int ROWS        = 25;
  localparam int LINE_CAP    = 128;
  localparam int CYCLE_LIMIT = 250000;

  // A few release codes used by the directed part
  localparam logic [7:0] REL_A     = 8'h9E;
  localparam logic [7:0] REL_W     = 8'h91;
  localparam logic [7:0] REL_D     = 8'hA0;
  localparam logic [7:0] REL_1     = 8'h82;
  localparam logic [7:0] REL_0     = 8'h8B;
  localparam logic [7:0] REL_SPACE = 8'hB9;
  localparam logic [7:0] REL_M     = 8'hB2;
  localparam logic [7:0] CODE_NULL = 8'h00;
  localparam logic [7:0] CODE_ALL1 = 8'hFF;
  localparam logic [7:0] ENTER_DN  = 8'h1C;

  // --------------------------------------------------------------------------
  // Console model: cursor, caps, prefix and line length, one beat per byte
  // --------------------------------------------------------------------------
  class console_scoreboard;
    int                  col, row, line_len;
    bit                  caps, ext_pend;
    logic [7:0]          attr;
    stcon_pkg::result_t  expected_beats[$];
    int                  errors;

    function new();
      errors = 0;
      clear();
    endfunction

    function void clear();
      col      = 0;
      row      = int'(stcon_pkg::ROW_RESET);
      line_len = 0;
      caps     = 0;
      ext_pend = 0;
      attr     = stcon_pkg::ATTR_RESET;
      expected_beats.delete();
    endfunction

    // Character typed by a release code; rows of the set-1 layout
    static function logic [7:0] release_char(logic [7:0] code);
      string digits = "1234567890";
      string qrow   = "qwertyuiop";
      string arow   = "asdfghjkl";
      string zrow   = "zxcvbnm";
      int    m;
      if (code < 8'h80) return stcon_pkg::CHAR_NONE;
      m = int'(code) - 'h80;
      if (m >= 'h02 && m <= 'h0B) return digits[m - 'h02];
      if (m == 'h39)              return stcon_pkg::CHAR_SPACE;
      if (m >= 'h10 && m <= 'h19) return qrow[m - 'h10];
      if (m >= 'h1E && m <= 'h26) return arow[m - 'h1E];
      if (m >= 'h2C && m <= 'h32) return zrow[m - 'h2C];
      return stcon_pkg::CHAR_NONE;
    endfunction

    function logic [10:0] cursor_cell();
      return 11'((row * COLS + col) & 'h7FF);
    endfunction

    // Accepted input byte: advance the console and queue the beat it gives
    function void note_key(logic [7:0] code);
      stcon_pkg::result_t r;
      bit                 was_ext;
      logic [7:0]         ch;
      r       = '0;
      was_ext = ext_pend;
      if (code == stcon_pkg::CODE_PREFIX) begin
        ext_pend = 1;
      end else begin
        ext_pend = 0;
        ch = release_char(code);
        if (was_ext && code == stcon_pkg::CODE_LEFT) begin
          if (col > 0) col--;
        end else if (was_ext && code == stcon_pkg::CODE_RIGHT) begin
          if (col + 1 < COLS) col++;
        end else if (was_ext && code == stcon_pkg::CODE_UP) begin
          if (row > 0) row--;
        end else if (was_ext && code == stcon_pkg::CODE_DOWN) begin
          if (row + 1 < ROWS) row++;
        end else if (ch != stcon_pkg::CHAR_NONE) begin
          if (caps && ch >= stcon_pkg::CHAR_LOW_A && ch <= stcon_pkg::CHAR_LOW_Z)
            ch = ch - stcon_pkg::CASE_OFFSET;
          r.cell_write     = 1;
          r.cell_position  = cursor_cell();
          r.cell_char      = ch;
          r.cell_attribute = attr;
          col++;
          if (col >= COLS) begin
            col = 0;
            row++;
            if (row >= ROWS) begin
              row         = ROWS - 1;
              r.scroll_up = 1;
            end
          end
          if (line_len < LINE_CAP) begin
            r.line_write = 1;
            r.line_slot  = 7'(line_len);
            r.line_char  = ch;
            line_len++;
          end
        end else if (code == stcon_pkg::CODE_ENTER_UP) begin
          col = 0;
          if (row + 1 < ROWS) row++;
          line_len    = 0;
          r.line_done = 1;
        end else if (code == stcon_pkg::CODE_BACKSPACE) begin
          if (col > 0) begin
            col--;
          end else if (row > 0) begin
            row--;
            col = COLS - 1;
          end
          r.cell_write     = 1;
          r.cell_position  = cursor_cell();
          r.cell_char      = stcon_pkg::CHAR_SPACE;
          r.cell_attribute = stcon_pkg::ERASE_ATTR;
          if (line_len > 0) line_len--;
        end else if (code == stcon_pkg::CODE_CAPS) begin
          caps = !caps;
        end
      end
      r.cursor_position = cursor_cell();
      r.line_length     = 8'(line_len);
      expected_beats.push_back(r);
    endfunction

    function void cmp(string name, int unsigned exp, int unsigned got);
      if (exp != got) begin
        $error("%s: expected %0d, got %0d", name, exp, got);
        errors++;
      end
    endfunction

    // Accepted result beat: compare against the oldest queued beat
    function void check_beat(stcon_pkg::result_t got);
      stcon_pkg::result_t e;
      if (expected_beats.size() == 0) begin
        $error("result beat with nothing expected");
        errors++;
        return;
      end
      e = expected_beats.pop_front();
      cmp("cell_write",      e.cell_write,      got.cell_write);
      cmp("cell_position",   e.cell_position,   got.cell_position);
      cmp("cell_char",       e.cell_char,       got.cell_char);
      cmp("cell_attribute",  e.cell_attribute,  got.cell_attribute);
      cmp("scroll_up",       e.scroll_up,       got.scroll_up);
      cmp("cursor_position", e.cursor_position, got.cursor_position);
      cmp("line_write",      e.line_write,      got.line_write);
      cmp("line_slot",       e.line_slot,       got.line_slot);
      cmp("line_char",       e.line_char,       got.line_char);
      cmp("line_length",     e.line_length,     got.line_length);
      cmp("line_done",       e.line_done,       got.line_done);
    endfunction

    function int pending();
      return expected_beats.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // DUT and its signals
  // --------------------------------------------------------------------------
  logic        clk = 1'b0;
  logic        rst;
  logic        push;
  logic        full;
  logic [7:0]  key_code;
  logic        attr_write;
  logic [7:0]  attr_data;
  logic        empty;
  logic        pop;
  logic        cell_write;
  logic [10:0] cell_position;
  logic [7:0]  cell_char;
  logic [7:0]  cell_attribute;
  logic        scroll_up;
  logic [10:0] cursor_position;
  logic        line_write;
  logic [6:0]  line_slot;
  logic [7:0]  line_char;
  logic [7:0]  line_length;
  logic        line_done;

  scancode_text_console_unit #(
    .LINE_CAPACITY  (LINE_CAP),
    .SCREEN_COLUMNS (COLS),
    .SCREEN_ROWS    (ROWS)
  ) u_top (
    .clk             (clk),
    .rst             (rst),
    .push            (push),
    .full            (full),
    .key_code        (key_code),
    .attr_write      (attr_write),
    .attr_data       (attr_data),
    .empty           (empty),
    .pop             (pop),
    .cell_write      (cell_write),
    .cell_position   (cell_position),
    .cell_char       (cell_char),
    .cell_attribute  (cell_attribute),
    .scroll_up       (scroll_up),
    .cursor_position (cursor_position),
    .line_write      (line_write),
    .line_slot       (line_slot),
    .line_char       (line_char),
    .line_length     (line_length),
    .line_done       (line_done)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  console_scoreboard sb = new();
  logic [7:0]        typing_codes[$];   // every release code that types a character
  logic [7:0]        arrow_codes[4];
  int                send_idle;         // percent of cycles the sender holds off
  int                recv_idle;         // percent of cycles the receiver stalls
  int                items_sent;
  int                cycles;

  // Watchdog: a hung handshake ends the run here
  initial cycles = 0;
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Receiver: pop changes on the falling edge, stalls at recv_idle percent
  initial begin
    pop = 1'b0;
    forever begin
      @(negedge clk);
      pop <= ($urandom_range(0, 99) >= recv_idle);
    end
  end

  // Monitor: a result beat moves at a rising edge with pop high and empty low
  always @(posedge clk) begin
    if (rst === 1'b0 && pop && !empty)
      sb.check_beat('{cell_write, cell_position, cell_char, cell_attribute, scroll_up,
                      cursor_position, line_write, line_slot, line_char, line_length,
                      line_done});
  end

  // --------------------------------------------------------------------------
  // Drivers; each is entered and left at a falling edge
  // --------------------------------------------------------------------------

  // One input beat, after a random hold-off
  task automatic send_byte(input logic [7:0] code);
    while ($urandom_range(0, 99) < send_idle) begin
      push <= 1'b0;
      @(negedge clk);
    end
    push     <= 1'b1;
    key_code <= code;
    do @(posedge clk); while (full);
    sb.note_key(code);
    items_sent++;
    @(negedge clk);
  endtask

  // Hold off the sender until every queued beat has been popped
  task automatic drain();
    push <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // Attribute write; only called with the block idle
  task automatic write_attr(input logic [7:0] value);
    attr_write <= 1'b1;
    attr_data  <= value;
    @(negedge clk);
    attr_write <= 1'b0;
    attr_data  <= 8'($urandom_range(0, 255));
    sb.attr = value;
  endtask

  task automatic send_arrow(input logic [7:0] code);
    send_byte(stcon_pkg::CODE_PREFIX);
    send_byte(code);
  endtask

  // Random phase: mostly typed text and cursor moves, some noise
  task automatic run_phase(input bit bottom_run, input int budget);
    int         start;
    int         n;
    int         kind;
    bit         paused;
    logic [7:0] dir;
    start  = items_sent;
    paused = 0;
    // Enters down to the last row (and past it), then a line longer than the
    // store: wraps at the bottom with a scroll and runs the line store full.
    if (bottom_run) begin
      repeat (ROWS + 1) send_byte(stcon_pkg::CODE_ENTER_UP);
      repeat (LINE_CAP + 4) send_byte(typing_codes[$urandom_range(0, typing_codes.size() - 1)]);
    end
    while (items_sent - start < budget) begin
      if (!paused && items_sent - start >= budget / 2) begin
        drain();
        paused = 1;
      end
      kind = $urandom_range(0, 99);
      if (kind < 45) begin
        n = $urandom_range(1, 16);
        repeat (n) send_byte(typing_codes[$urandom_range(0, typing_codes.size() - 1)]);
      end else if (kind < 60) begin
        // occasionally long enough to pin the cursor at an edge
        dir = arrow_codes[$urandom_range(0, 3)];
        n   = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 85) : $urandom_range(1, 6);
        repeat (n) send_arrow(dir);
      end else if (kind < 70) begin
        n = $urandom_range(1, 8);
        repeat (n) send_byte(stcon_pkg::CODE_BACKSPACE);
      end else if (kind < 76) begin
        send_byte(stcon_pkg::CODE_ENTER_UP);
      end else if (kind < 81) begin
        send_byte(stcon_pkg::CODE_CAPS);
      end else if (kind < 86) begin
        send_byte(stcon_pkg::CODE_PREFIX);
        send_byte(8'($urandom_range(0, 255)));
      end else begin
        send_byte(8'($urandom_range(0, 255)));
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    rst        = 1'b1;
    push       = 1'b0;
    key_code   = '0;
    attr_write = 1'b0;
    attr_data  = '0;
    send_idle  = 17;
    recv_idle  = 47;
    items_sent = 0;
    arrow_codes = '{stcon_pkg::CODE_LEFT, stcon_pkg::CODE_RIGHT,
                    stcon_pkg::CODE_UP, stcon_pkg::CODE_DOWN};
    for (int c = 'h80; c <= 'hFF; c++)
      if (console_scoreboard::release_char(8'(c)) != stcon_pkg::CHAR_NONE)
        typing_codes.push_back(8'(c));

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    sb.clear();
    @(negedge clk);

    // Directed part, reset attribute. Starts at row 2 col 0: up twice reaches
    // the top-left corner for the erase-at-origin and empty-line cases.
    send_arrow(stcon_pkg::CODE_UP);
    send_arrow(stcon_pkg::CODE_UP);
    send_byte(stcon_pkg::CODE_BACKSPACE);
    send_arrow(stcon_pkg::CODE_UP);        // up against the top edge
    send_arrow(stcon_pkg::CODE_LEFT);      // left against the left edge
    send_byte(stcon_pkg::CODE_CAPS);
    send_byte(REL_A);
    send_byte(REL_W);
    send_byte(REL_D);
    send_byte(stcon_pkg::CODE_CAPS);
    send_byte(REL_W);
    send_byte(REL_D);
    send_byte(REL_1);
    send_byte(REL_0);
    send_byte(REL_SPACE);
    send_byte(REL_M);
    send_byte(stcon_pkg::CODE_BACKSPACE);
    send_arrow(stcon_pkg::CODE_RIGHT);
    send_arrow(stcon_pkg::CODE_DOWN);
    send_arrow(REL_A);                     // extended non-arrow still types
    send_byte(stcon_pkg::CODE_PREFIX);     // doubled prefix, then an arrow
    send_arrow(stcon_pkg::CODE_LEFT);
    send_byte(CODE_NULL);
    send_byte(CODE_ALL1);
    send_byte(ENTER_DN);                   // enter press types nothing
    send_byte(stcon_pkg::CODE_ENTER_UP);
    send_byte(stcon_pkg::CODE_BACKSPACE);  // column zero: back to the row above

    // Random phases, attribute changed only with the pipe empty
    drain();
    write_attr(8'h00);
    run_phase(1'b1, 300);

    drain();
    send_idle = 47;
    recv_idle = 17;
    write_attr(8'hFF);
    run_phase(1'b0, 175);

    drain();
    send_idle = 0;
    recv_idle = 0;
    write_attr(8'($urandom_range(1, 254)));
    run_phase(1'b0, 175);

    // Wind down: everything popped, then a few quiet cycles for stray beats
    drain();
    repeat (8) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

// ===== filelist.f =====
design/stcon_pkg.sv
design/stcon_fifo.sv
design/stcon_front.sv
design/stcon_back.sv
design/scancode_text_console_unit.sv
bench/tb_scancode_text_console_unit.sv
